// ===== rtl/edd_pkg.sv =====
package edd_pkg;

    // Row store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Configuration field widths and reset values
    localparam int BITS_W   = 4;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 16;
    localparam int CMP_W    = (ADDR_W + 1 > WIDTH_W) ? ADDR_W + 1 : WIDTH_W;

    localparam logic [BITS_W-1:0]   RST_QUANT_BITS   = 4'd8;
    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 16'd480;

    // Error word: three signed 9-bit channel errors, red in the low bits
    localparam int NUM_CH = 3;
    localparam int ERR_W  = 9;
    localparam int ROW_W  = NUM_CH * ERR_W;

    // floor(t / 510) by reciprocal: floor(t * REC510 / 2^SHIFT510), t < 2^17
    localparam logic [17:0] REC510     = 18'd131587;
    localparam int          SHIFT510   = 26;
    // floor(n / L) by reciprocal for n < 2^16
    localparam int          SCALE_SHIFT = 24;

    typedef enum logic [1:0] {
        REG_QUANT_BITS   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SUM,
        ST_QUANT,
        ST_SCALE
    } state_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       end_of_frame;
    } pixel_out_t;

    // err * w / 16, truncated toward zero
    function automatic logic signed [7:0] diffuse_term(input logic signed [ERR_W-1:0] e,
                                                       input logic [2:0] w);
        logic signed [11:0] ex;
        logic signed [11:0] wx;
        logic signed [11:0] p;
        logic signed [11:0] r;
        ex = {{(12-ERR_W){e[ERR_W-1]}}, e};
        wx = {9'd0, w};
        p  = ex * wx;
        if (p[11]) begin
            r = (p + 12'sd15) >>> 4;
        end else begin
            r = p >>> 4;
        end
        return r[7:0];
    endfunction

    // v + t, clamped to 0..255
    function automatic logic [7:0] clamp_add(input logic [7:0] v, input logic signed [7:0] t);
        logic signed [9:0] s;
        s = $signed({2'b00, v}) + $signed({{2{t[7]}}, t});
        if (s[9]) begin
            return 8'd0;
        end else if (s[8]) begin
            return 8'd255;
        end else begin
            return s[7:0];
        end
    endfunction

    // ceil(2^SCALE_SHIFT / (2^bits - 1)) for bits 1..8
    function automatic logic [24:0] scale_recip(input logic [BITS_W-1:0] bits);
        logic [24:0] r;
        case (bits)
            4'd1:    r = 25'd16777216;
            4'd2:    r = 25'd5592406;
            4'd3:    r = 25'd2396746;
            4'd4:    r = 25'd1118482;
            4'd5:    r = 25'd541201;
            4'd6:    r = 25'd266306;
            4'd7:    r = 25'd132105;
            default: r = 25'd65794;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/error_diffusion_dither.sv =====
// An accepted item steps through ST_SUM, ST_QUANT and ST_SCALE, with ST_FETCH before ST_SUM when no
// above entry is held, as on the first pixel of a row. s_ready is high only in ST_IDLE, so a new item is
// taken only once the last result is committed; the single read port of the row error memory needs a
// second read in ST_FETCH, and the quantizer registers each reciprocal multiply. A stalled result holds the block.
// Reset (aresetn low, synchronous): clears counters, left errors and the held entry,
// loads quant_bits 8, image_width 640, image_height 480; the row memory is not cleared.
module error_diffusion_dither (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  edd_pkg::pixel_in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output edd_pkg::pixel_out_t   m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int AW = edd_pkg::ADDR_W;
    localparam int EW = edd_pkg::ERR_W;
    localparam int RW = edd_pkg::ROW_W;
    localparam int CW = edd_pkg::CMP_W;

    // Configuration registers
    logic [edd_pkg::BITS_W-1:0]   quant_bits_reg;
    logic [edd_pkg::WIDTH_W-1:0]  image_width_reg;
    logic [edd_pkg::HEIGHT_W-1:0] image_height_reg;

    // Control and datapath registers
    edd_pkg::state_t      state_reg, state_next;
    edd_pkg::pixel_in_t   in_reg;
    edd_pkg::pixel_out_t  out_reg;
    logic                 m_valid_reg;
    logic [AW-1:0]        col_reg;
    logic [15:0]          row_reg;
    logic [RW-1:0]        above_reg;
    logic [RW-1:0]        right_reg;
    logic [RW-1:0]        left_reg;
    logic [RW-1:0]        upleft_reg;
    logic                 hold_valid_reg;
    logic [7:0]           v_reg [edd_pkg::NUM_CH];
    logic [7:0]           q_reg [edd_pkg::NUM_CH];

    // Row error memory
    logic [RW-1:0]        row_mem [edd_pkg::MAX_WIDTH];
    logic [RW-1:0]        mem_rdata_reg;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic                 mem_we;
    logic [RW-1:0]        mem_wdata;

    // Combinational
    logic                        s_accept;
    logic                        commit;
    logic [edd_pkg::BITS_W-1:0]  bits_c;
    logic [CW-1:0]               width_c;
    logic [16:0]                 height_c;
    logic                        last_col;
    logic                        last_row;
    logic                        has_above;
    logic                        has_left;
    logic                        has_right;
    logic [AW-1:0]               col_inc;
    logic [7:0]                  pix [edd_pkg::NUM_CH];
    logic [7:0]                  v_sum [edd_pkg::NUM_CH];
    logic [7:0]                  q_val [edd_pkg::NUM_CH];
    logic [7:0]                  o_val [edd_pkg::NUM_CH];
    logic [EW-1:0]               err_val [edd_pkg::NUM_CH];
    logic [24:0]                 recip;

    assign s_ready   = (state_reg == edd_pkg::ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign commit    = (state_reg == edd_pkg::ST_SCALE) && (!m_valid_reg || m_ready);

    // Clamp configuration to its working range
    always_comb begin
        if (quant_bits_reg == '0) begin
            bits_c = 4'd1;
        end else if (quant_bits_reg > 4'd8) begin
            bits_c = 4'd8;
        end else begin
            bits_c = quant_bits_reg;
        end
        if (image_width_reg == '0) begin
            width_c = CW'(1);
        end else if (CW'(image_width_reg) > CW'(edd_pkg::MAX_WIDTH)) begin
            width_c = CW'(edd_pkg::MAX_WIDTH);
        end else begin
            width_c = CW'(image_width_reg);
        end
        height_c = (image_height_reg == '0) ? 17'd1 : {1'b0, image_height_reg};
    end

    // Raster position flags
    assign col_inc   = col_reg + AW'(1);
    assign last_col  = (CW'(col_reg) + CW'(1)) >= width_c;
    assign last_row  = ({1'b0, row_reg} + 17'd1) >= height_c;
    assign has_above = (row_reg != '0);
    assign has_left  = (col_reg != '0);
    assign has_right = !last_col;
    assign recip     = edd_pkg::scale_recip(bits_c);

    assign pix[0] = in_reg.red_in;
    assign pix[1] = in_reg.green_in;
    assign pix[2] = in_reg.blue_in;

    // Apply diffused errors: above-left, above, above-right, then left
    always_comb begin
        for (int c = 0; c < edd_pkg::NUM_CH; c++) begin
            v_sum[c] = pix[c];
            if (has_above) begin
                if (has_left) begin
                    v_sum[c] = edd_pkg::clamp_add(v_sum[c],
                        edd_pkg::diffuse_term(upleft_reg[c*EW +: EW], 3'd1));
                end
                v_sum[c] = edd_pkg::clamp_add(v_sum[c],
                    edd_pkg::diffuse_term(above_reg[c*EW +: EW], 3'd5));
                if (has_right) begin
                    v_sum[c] = edd_pkg::clamp_add(v_sum[c],
                        edd_pkg::diffuse_term(mem_rdata_reg[c*EW +: EW], 3'd3));
                end
            end
            if (has_left) begin
                v_sum[c] = edd_pkg::clamp_add(v_sum[c],
                    edd_pkg::diffuse_term(left_reg[c*EW +: EW], 3'd7));
            end
        end
    end

    // Quantize: q = round(v * L / 255), output = floor(q * 255 / L)
    always_comb begin
        logic [15:0] vl;
        logic [16:0] t;
        logic [34:0] p1;
        logic [15:0] n;
        logic [40:0] p2;
        for (int c = 0; c < edd_pkg::NUM_CH; c++) begin
            vl         = ({8'd0, v_reg[c]} << bits_c) - {8'd0, v_reg[c]};
            t          = {vl, 1'b0} + 17'd255;
            p1         = 35'(t) * 35'(edd_pkg::REC510);
            q_val[c]   = p1[edd_pkg::SHIFT510 +: 8];
            n          = {q_reg[c], 8'd0} - {8'd0, q_reg[c]};
            p2         = 41'(n) * 41'(recip);
            o_val[c]   = p2[edd_pkg::SCALE_SHIFT +: 8];
            err_val[c] = {1'b0, v_reg[c]} - {1'b0, o_val[c]};
        end
    end

    // Next state and memory control
    always_comb begin
        state_next = state_reg;
        mem_re     = 1'b0;
        mem_raddr  = col_inc;
        mem_we     = 1'b0;
        mem_wdata  = {err_val[2], err_val[1], err_val[0]};
        case (state_reg)
            edd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    mem_re     = 1'b1;
                    mem_raddr  = hold_valid_reg ? col_inc : col_reg;
                    state_next = hold_valid_reg ? edd_pkg::ST_SUM : edd_pkg::ST_FETCH;
                end
            end
            edd_pkg::ST_FETCH: begin
                mem_re     = 1'b1;
                state_next = edd_pkg::ST_SUM;
            end
            edd_pkg::ST_SUM: begin
                state_next = edd_pkg::ST_QUANT;
            end
            edd_pkg::ST_QUANT: begin
                state_next = edd_pkg::ST_SCALE;
            end
            edd_pkg::ST_SCALE: begin
                if (commit) begin
                    mem_we     = 1'b1;
                    state_next = edd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = edd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= edd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Row error memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            row_mem[col_reg] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= row_mem[mem_raddr];
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quant_bits_reg   <= edd_pkg::RST_QUANT_BITS;
            image_width_reg  <= edd_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= edd_pkg::RST_IMAGE_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                edd_pkg::REG_QUANT_BITS:   quant_bits_reg   <= cfg_data[edd_pkg::BITS_W-1:0];
                edd_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[edd_pkg::WIDTH_W-1:0];
                edd_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_data;
        end
        if (state_reg == edd_pkg::ST_FETCH) begin
            above_reg <= mem_rdata_reg;
        end
        if (state_reg == edd_pkg::ST_SUM) begin
            right_reg <= mem_rdata_reg;
            v_reg     <= v_sum;
        end
        if (state_reg == edd_pkg::ST_QUANT) begin
            q_reg <= q_val;
        end
        if (commit) begin
            above_reg            <= right_reg;
            out_reg.red_out      <= o_val[0];
            out_reg.green_out    <= o_val[1];
            out_reg.blue_out     <= o_val[2];
            out_reg.end_of_frame <= last_col && last_row;
        end
    end

    // Error state, raster counters and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= '0;
            upleft_reg     <= '0;
            hold_valid_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (commit) begin
                left_reg       <= mem_wdata;
                upleft_reg     <= above_reg;
                hold_valid_reg <= !last_col;
                m_valid_reg    <= 1'b1;
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 16'd1;
                end else begin
                    col_reg <= col_inc;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Reads and writes of the row memory never share a cycle
    a_mem_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_re && mem_we))
        else $error("row memory read and write in the same cycle");

    // A held above entry never stands for the first column
    a_hold_not_first: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (col_reg != '0))
        else $error("held above entry at column zero");

    // An accepted item leaves the idle state
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != edd_pkg::ST_IDLE))
        else $error("still idle after accepting an item");

    // The last pixel of the frame wraps both counters
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && last_col && last_row) |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters did not wrap at end of frame");

    // A committed result is presented
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid_reg && (state_reg == edd_pkg::ST_IDLE))
        else $error("result not presented after commit");

endmodule

// ===== sim/tb_error_diffusion_dither.sv =====
module tb_error_diffusion_dither;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int             ITEM_TARGET  = 1850;
    localparam int             TAIL_START   = 1550;
    localparam int             LONG_HOLD    = 300;
    localparam int             DRAIN_CYCLES = 8;
    localparam int             TIMEOUT_NS   = 1_000_000;
    localparam logic [1:0]     REG_SPARE    = 2'd3;

    // Directed pixels: extremes, mid-scale thresholds and mixed channels
    localparam edd_pkg::pixel_in_t DIRECTED_PIXELS [22] = '{
        24'h000000, 24'hFFFFFF, 24'h807F01, 24'hFE0180, 24'h7F80FF, 24'h01FE00,
        24'h55AA55, 24'hAA55AA, 24'h2AD540, 24'hC03F15, 24'h00FF00, 24'hFF00FF,
        24'h7F7F7F, 24'h808080, 24'h7F807F, 24'h0000FF, 24'hFFFF00, 24'h807F80,
        24'h000000, 24'hFFFFFF, 24'h0FF03C, 24'hC35AA5
    };

    // Dither predictor plus the queue of pixels it still expects
    class dither_scoreboard;
        edd_pkg::pixel_out_t          expected_pixels[$];
        int                           mismatches;
        logic [edd_pkg::BITS_W-1:0]   quant_bits;
        logic [edd_pkg::WIDTH_W-1:0]  image_width;
        logic [edd_pkg::HEIGHT_W-1:0] image_height;
        int                           row_err[edd_pkg::MAX_WIDTH][edd_pkg::NUM_CH];
        int                           left_err[edd_pkg::NUM_CH];
        int                           upleft_err[edd_pkg::NUM_CH];
        int                           column;
        int                           row;
        int                           written_span;

        function new();
            quant_bits   = edd_pkg::RST_QUANT_BITS;
            image_width  = edd_pkg::RST_IMAGE_WIDTH;
            image_height = edd_pkg::RST_IMAGE_HEIGHT;
        endfunction

        static function int spread(int e, int w);
            return (e * w) / 16;
        endfunction

        static function int add_clamped(int v, int t);
            int s;
            s = v + t;
            if (s < 0) return 0;
            if (s > 255) return 255;
            return s;
        endfunction

        static function int effective_width(logic [edd_pkg::WIDTH_W-1:0] wd);
            if (wd == 0) return 1;
            if (wd > edd_pkg::MAX_WIDTH) return edd_pkg::MAX_WIDTH;
            return wd;
        endfunction

        // A wider row may only be read back once the store holds every column of it
        function bit width_safe(logic [edd_pkg::WIDTH_W-1:0] wd);
            return row == 0 || effective_width(wd) <= written_span;
        endfunction

        function void note_config(logic [1:0] idx, logic [15:0] val);
            case (idx)
                edd_pkg::REG_QUANT_BITS:   quant_bits   = val[edd_pkg::BITS_W-1:0];
                edd_pkg::REG_IMAGE_WIDTH:  image_width  = val[edd_pkg::WIDTH_W-1:0];
                edd_pkg::REG_IMAGE_HEIGHT: image_height = val[edd_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(edd_pkg::pixel_in_t px);
            int                  bits, w, h, x, y, v, levels, q;
            int                  chan_in[edd_pkg::NUM_CH];
            int                  above[edd_pkg::NUM_CH];
            int                  above_right[edd_pkg::NUM_CH];
            int                  err[edd_pkg::NUM_CH];
            int                  quant_out[edd_pkg::NUM_CH];
            bit                  last_col, last_row, has_above, has_left, has_right;
            edd_pkg::pixel_out_t pix;

            bits = quant_bits;
            if (bits < 1) bits = 1;
            else if (bits > 8) bits = 8;
            w = effective_width(image_width);
            h = (image_height == 0) ? 1 : image_height;
            x = (column >= edd_pkg::MAX_WIDTH) ? edd_pkg::MAX_WIDTH - 1 : column;
            y = row;

            last_col  = (x + 1 >= w);
            last_row  = (y + 1 >= h);
            has_above = (y > 0);
            has_left  = (x > 0);
            has_right = !last_col;
            chan_in   = '{px.red_in, px.green_in, px.blue_in};
            levels    = (1 << bits) - 1;

            // Apply row-above terms, then the left term, then quantize
            for (int c = 0; c < edd_pkg::NUM_CH; c++) begin
                above[c]       = row_err[x][c];
                above_right[c] = has_right ? row_err[x + 1][c] : 0;
                v = chan_in[c];
                if (has_above) begin
                    if (has_left) v = add_clamped(v, spread(upleft_err[c], 1));
                    v = add_clamped(v, spread(above[c], 5));
                    if (has_right) v = add_clamped(v, spread(above_right[c], 3));
                end
                if (has_left) v = add_clamped(v, spread(left_err[c], 7));
                q = (2 * v * levels + 255) / 510;
                quant_out[c] = (q * 255) / levels;
                err[c] = v - quant_out[c];
            end

            // Update error state and advance the raster position
            for (int c = 0; c < edd_pkg::NUM_CH; c++) begin
                upleft_err[c] = above[c];
                row_err[x][c] = err[c];
                left_err[c]   = err[c];
            end
            if (x + 1 > written_span) written_span = x + 1;
            if (last_col) begin
                column = 0;
                row    = last_row ? 0 : ((y + 1) & 16'hFFFF);
            end else begin
                column = x + 1;
            end

            pix.red_out      = 8'(quant_out[0]);
            pix.green_out    = 8'(quant_out[1]);
            pix.blue_out     = 8'(quant_out[2]);
            pix.end_of_frame = last_col && last_row;
            expected_pixels.push_back(pix);
        endfunction

        function void check_result(edd_pkg::pixel_out_t got);
            edd_pkg::pixel_out_t want;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel %h with nothing pending", $time, got);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out || got.end_of_frame !== want.end_of_frame) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: want rgb %0d %0d %0d eof %0b, got rgb %0d %0d %0d eof %0b",
                             $time, want.red_out, want.green_out, want.blue_out,
                             want.end_of_frame, got.red_out, got.green_out, got.blue_out,
                             got.end_of_frame);
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    edd_pkg::pixel_in_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    edd_pkg::pixel_out_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [15:0]         cfg_data  = '0;

    dither_scoreboard board = new();
    int  sent_total    = 0;
    int  directed_next = 0;
    bit  quiet_tail    = 1'b0;
    bit  long_hold_req = 1'b0;

    error_diffusion_dither u_top (
        .aclk,
        .aresetn,
        .s_valid,
        .s_ready,
        .s_data,
        .m_valid,
        .m_ready,
        .m_data,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    always #1 aclk = ~aclk;

    // Hold the write until accepted; the caller drops cfg_valid after the last one
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.note_config(idx, val);
    endtask

    // Offer one pixel and hold it until accepted; the caller drops s_valid
    task automatic send_pixel(edd_pkg::pixel_in_t px);
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        board.note_pixel(px);
        sent_total++;
        if (sent_total >= TAIL_START) quiet_tail = 1'b1;
    endtask

    task automatic run_phase(logic [edd_pkg::BITS_W-1:0] qb,
                             logic [edd_pkg::WIDTH_W-1:0] wd,
                             logic [edd_pkg::HEIGHT_W-1:0] ht,
                             int count, bit directed, bit hold_off);
        edd_pkg::pixel_in_t px;
        logic [15:0]        junk;

        // Program the block while it is idle; sometimes with junk in unused bits
        junk = $urandom();
        if (directed || $urandom_range(0, 3) == 0) write_reg(REG_SPARE, junk);
        if ($urandom_range(0, 3) != 0) junk = '0;
        write_reg(edd_pkg::REG_QUANT_BITS, {junk[15:edd_pkg::BITS_W], qb});
        write_reg(edd_pkg::REG_IMAGE_WIDTH, {junk[15:edd_pkg::WIDTH_W], wd});
        write_reg(edd_pkg::REG_IMAGE_HEIGHT, ht);
        cfg_valid <= 1'b0;

        for (int i = 0; i < count; i++) begin
            if (directed) begin
                px = DIRECTED_PIXELS[directed_next];
                directed_next++;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        px.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        px.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        px.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end
                    1: begin
                        px.red_in   = 8'($urandom_range(126, 129));
                        px.green_in = 8'($urandom_range(126, 129));
                        px.blue_in  = 8'($urandom_range(126, 129));
                    end
                    default: px = 24'($urandom());
                endcase
            end
            send_pixel(px);
            if (hold_off && i == 3) long_hold_req = 1'b1;
            // Drop valid after the last pixel, or idle for a random burst
            if (i == count - 1) begin
                s_valid <= 1'b0;
            end else if (!hold_off && !quiet_tail && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end

        // Wait for every pending pixel, then let the pipeline settle
        while (board.expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Check accepted results and stall the output side in random bursts
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) board.check_result(m_data);
            if (stall_left > 0) stall_left--;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            m_ready <= (stall_left == 0);
        end
    end

    initial begin : stimulus
        logic [edd_pkg::BITS_W-1:0]   qb;
        logic [edd_pkg::WIDTH_W-1:0]  wd;
        logic [edd_pkg::HEIGHT_W-1:0] ht;
        int                           count;
        int                           pick;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: small frames, zero and oversized bit counts, zero height
        run_phase(4'd2, 12'd4, 16'd3, 12, 1'b1, 1'b0);
        run_phase(4'd0, 12'd3, 16'd2, 6, 1'b1, 1'b0);
        run_phase(4'd15, 12'd1, 16'd0, 4, 1'b1, 1'b0);

        // Widest rows from the frame start, then shrink below the current column
        run_phase(4'd8, 12'd2048, 16'd65535, 30, 1'b0, 1'b0);
        run_phase(4'd9, 12'd4095, 16'd2, 20, 1'b0, 1'b0);
        run_phase(4'd1, 12'd7, 16'd3, 70, 1'b0, 1'b1);
        // Shrink the height below the current row
        run_phase(4'd3, 12'd6, 16'd10, 26, 1'b0, 1'b0);
        run_phase(4'd3, 12'd6, 16'd1, 30, 1'b0, 1'b0);

        // Random settings, mostly small frames
        while (sent_total < ITEM_TARGET) begin
            pick = $urandom_range(0, 3);
            qb = (pick == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
            pick = $urandom_range(0, 19);
            if (pick == 0) wd = '0;
            else if (pick == 1) wd = 12'($urandom_range(edd_pkg::MAX_WIDTH, 4095));
            else if (pick <= 4) wd = 12'($urandom_range(13, 64));
            else wd = 12'($urandom_range(1, 12));
            if (!board.width_safe(wd)) wd = 12'($urandom_range(1, board.written_span));
            pick = $urandom_range(0, 9);
            if (pick == 0) ht = '0;
            else if (pick == 1) ht = 16'hFFFF;
            else if (pick == 2) ht = 16'($urandom());
            else ht = 16'($urandom_range(1, 6));
            count = (board.effective_width(wd) > 64) ? $urandom_range(10, 40)
                                                      : $urandom_range(20, 120);
            run_phase(qb, wd, ht, count, 1'b0, 1'b0);
        end

        if (board.mismatches == 0 && board.expected_pixels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
